// File: src/u2u_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int unsigned POINT_W = 21;
  localparam int unsigned UNIT_W  = 16;

  typedef logic [POINT_W-1:0] point_t;
  typedef logic [UNIT_W-1:0]  unit_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_of_string;
  } in_item_t;

  typedef struct packed {
    unit_t code_unit;
    logic  last_unit;
    logic  beyond_range;
  } out_item_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

  // Byte class limits.
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;

  // Payload masks.
  localparam logic [7:0] CONT_MASK  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;

  // Continuation counts loaded by lead bytes.
  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // Surrogate encoding.
  localparam point_t BMP_MAX    = 21'h00FFFF;
  localparam point_t POINT_MAX  = 21'h10FFFF;
  localparam point_t SUPP_BASE  = 21'h010000;
  localparam unit_t  HI_SURR    = 16'hD800;
  localparam unit_t  LO_SURR    = 16'hDC00;
  localparam unit_t  SURR_MASK  = 16'h03FF;

endpackage
`default_nettype wire

// File: src/utf8_to_utf16_decoder_core.sv
// Path: a byte that completes a code point is written into the point queue, and its
//   first unit is then loaded from the queue head into the output register.
// Throughput: one byte per cycle in while the queue has space; one unit per cycle out
//   when out_ready is high; the queue absorbs a pair holding the output register.
// Bytes that do not complete a point produce no unit.
// Reset: synchronous, active high; clears the partial point, the queue and out_valid.
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// UTF-8 byte stream to UTF-16 code units: a front end decodes bytes into
// code points, a short queue decouples it from the back end, which emits
// one unit or a surrogate pair per point from a registered output.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core #(
  parameter int unsigned QDEPTH = 2   // point queue depth, 2 or more
) (
  input  wire                 clk,
  input  wire                 rst,
  // byte items in
  input  wire                 in_valid,
  output logic                in_ready,
  input  u2u_pkg::in_item_t   in_data,
  // unit items out
  output logic                out_valid,
  input  wire                 out_ready,
  output u2u_pkg::out_item_t  out_data
);

  // front -> queue
  logic               push;
  u2u_pkg::point_t    push_point;
  // queue -> back
  logic               pop;
  u2u_pkg::point_t    head;
  u2u_pkg::q_status_t q_status;

  // Front: byte classification and point assembly. Ready only follows queue
  // space, so it keeps taking bytes while the back end stalls on a pair.
  u2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_point (push_point)
  );

  // Queue of finished code points.
  u2u_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_point (push_point),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back: UTF-16 encoding into the output register; the low surrogate waits
  // in a side register while the high one is presented.
  u2u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: src/u2u_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_front
// Accepts bytes, tracks the partial code point and pushes finished points.
// ----------------------------------------------------------------------------
module u2u_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  u2u_pkg::in_item_t   in_data,
  input  u2u_pkg::q_status_t  q_status,
  output logic                push,
  output u2u_pkg::point_t     push_point
);

  u2u_pkg::point_t partial_point;
  u2u_pkg::point_t partial_point_next;
  logic [1:0]      bytes_expected;
  logic [1:0]      bytes_expected_next;

  logic            accept;
  logic            emit;
  logic [7:0]      b;
  u2u_pkg::point_t pp0;
  logic [1:0]      be0;
  u2u_pkg::point_t point;

  assign in_ready = q_status.not_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    b     = in_data.byte_in;
    pp0   = in_data.start_of_string ? '0 : partial_point;
    be0   = in_data.start_of_string ? u2u_pkg::NEED_NONE : bytes_expected;
    point = pp0;
    emit  = 1'b0;
    bytes_expected_next = be0;
    if (b <= u2u_pkg::ASCII_MAX) begin
      point = u2u_pkg::POINT_W'(b);
      bytes_expected_next = u2u_pkg::NEED_NONE;
      emit = 1'b1;
    end else if (b <= u2u_pkg::CONT_MAX) begin
      if (be0 != u2u_pkg::NEED_NONE) begin
        point = {pp0[u2u_pkg::POINT_W-7:0], b[5:0] & u2u_pkg::CONT_MASK[5:0]};
        bytes_expected_next = be0 - 2'd1;
        emit = (bytes_expected_next == u2u_pkg::NEED_NONE);
      end else begin
        // stray continuation: point is zero here
        emit = 1'b1;
      end
    end else if (b <= u2u_pkg::LEAD2_MAX) begin
      point = u2u_pkg::POINT_W'(b & u2u_pkg::LEAD2_MASK);
      bytes_expected_next = u2u_pkg::NEED_ONE;
    end else if (b <= u2u_pkg::LEAD3_MAX) begin
      point = u2u_pkg::POINT_W'(b & u2u_pkg::LEAD3_MASK);
      bytes_expected_next = u2u_pkg::NEED_TWO;
    end else begin
      point = u2u_pkg::POINT_W'(b & u2u_pkg::LEAD4_MASK);
      bytes_expected_next = u2u_pkg::NEED_THREE;
    end
    partial_point_next = emit ? '0 : point;
  end

  assign push       = accept && emit;
  assign push_point = point;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point  <= '0;
      bytes_expected <= u2u_pkg::NEED_NONE;
    end else if (accept) begin
      partial_point  <= partial_point_next;
      bytes_expected <= bytes_expected_next;
    end
  end

endmodule
`default_nettype wire

// File: src/u2u_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_fifo
// Short queue of finished code points between front and back.
// ----------------------------------------------------------------------------
module u2u_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  u2u_pkg::point_t     push_point,
  input  wire                 pop,
  output u2u_pkg::point_t     head,
  output u2u_pkg::q_status_t  status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2u_pkg::point_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head             = mem[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.not_full  = (count != CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH))
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// File: src/u2u_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_back
// Turns queued code points into one unit or a surrogate pair.
// ----------------------------------------------------------------------------
module u2u_back (
  input  wire                 clk,
  input  wire                 rst,
  input  u2u_pkg::q_status_t  q_status,
  input  u2u_pkg::point_t     head,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output u2u_pkg::out_item_t  out_data
);

  logic            pend_valid;
  u2u_pkg::unit_t  pend_unit;
  logic            pend_over;

  logic            slot_free;
  logic            is_pair;
  logic            over;
  u2u_pkg::point_t v;
  u2u_pkg::unit_t  hi_unit;
  u2u_pkg::unit_t  lo_unit;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && !pend_valid && q_status.not_empty;

  always_comb begin
    is_pair = (head > u2u_pkg::BMP_MAX);
    over    = (head > u2u_pkg::POINT_MAX);
    v       = head - u2u_pkg::SUPP_BASE;
    hi_unit = u2u_pkg::HI_SURR + u2u_pkg::UNIT_W'(v[u2u_pkg::POINT_W-1:10]);
    lo_unit = u2u_pkg::LO_SURR + (u2u_pkg::unit_t'(v[9:0]) & u2u_pkg::SURR_MASK);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_status.not_empty) begin
        out_valid  <= 1'b1;
        pend_valid <= is_pair;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        out_data <= '{code_unit: pend_unit, last_unit: 1'b1, beyond_range: pend_over};
      end else if (is_pair) begin
        out_data  <= '{code_unit: hi_unit, last_unit: 1'b0, beyond_range: over};
        pend_unit <= lo_unit;
        pend_over <= over;
      end else begin
        out_data <= '{code_unit: head[u2u_pkg::UNIT_W-1:0], last_unit: 1'b1,
                      beyond_range: 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("low surrogate pending without high unit shown");
  a_pend_high_shown: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !out_data.last_unit)
    else $error("pending low surrogate behind a final unit");
  a_no_pop_pending: assert property (@(posedge clk) disable iff (rst)
    pop |-> !pend_valid)
    else $error("pop while a low surrogate is pending");
`endif

endmodule
`default_nettype wire
